// ===== sv/assert_macros.svh =====
// assertion macros shared by the deframer rtl
// no dependencies; synthesis builds define SYNTH to drop the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define CDF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent in a cycle implies consequent in the next
`define CDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CDF_ASSERT(lbl, clk, rst, prop)
`define CDF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/cdf_pkg.sv =====
// shared constants and types for the control frame deframer
// no dependencies
package cdf_pkg;

  // frame layout
  localparam int HIST_DEPTH = 5;
  localparam int WIN_LEN    = HIST_DEPTH + 1;

  localparam logic [7:0] SYNC_BYTE    = 8'h01;
  localparam logic [7:0] FLAG_MAX     = 8'h01;
  localparam logic [7:0] ZCAL_MAX     = 8'h02;
  localparam logic [7:0] STOP_PRESSED = 8'h00;

  // result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // control broadcast to every window cell
  typedef struct packed {
    logic shift;  // a word is taken this cycle
    logic full;   // this word completes a six byte window
    logic bad;    // the completed window failed its checks
  } cell_ctl_t;

  // decoded result of one completed window
  typedef struct packed {
    logic       status;
    logic       motion;
    logic       speed;
    logic [1:0] zcal;
    logic       estop;
  } frame_res_t;

endpackage

// ===== sv/cdf_cell.sv =====
// one cell of the byte window: holds a byte and its in-window bit
// depends on cdf_pkg and assert_macros.svh
`include "assert_macros.svh"

module cdf_cell (
  input  logic              clk,
  input  logic              rst,
  input  cdf_pkg::cell_ctl_t ctl,
  input  logic [7:0]        byte_in,
  input  logic              valid_in,
  input  logic              seen_in,
  output logic [7:0]        byte_q,
  output logic              valid_q,
  output logic              seen_out
);

  logic valid_next;

  // a sync among the bytes shifted into this cell or any cell to its left
  assign seen_out = seen_in | (byte_in == cdf_pkg::SYNC_BYTE);

  // window membership: follow the neighbor, clear on a good frame,
  // keep from the first later sync on a rejected frame
  always_comb begin
    if (ctl.full) begin
      valid_next = ctl.bad & seen_out;
    end else begin
      valid_next = valid_in;
    end
  end

  // byte stage
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_q <= byte_in;
    end
  end

  // membership flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctl.shift) begin
      valid_q <= valid_next;
    end
  end

  `CDF_ASSERT_NEXT(a_good_clears, clk, rst, ctl.shift && ctl.full && !ctl.bad, !valid_q)
  `CDF_ASSERT_NEXT(a_hold_idle, clk, rst, !ctl.shift, $stable(valid_q))
  `CDF_ASSERT_NEXT(a_reject_needs_sync, clk, rst, ctl.shift && ctl.full && !seen_out, !valid_q)

endmodule

// ===== sv/cdf_check.sv =====
// frame checker: field ranges, sync and additive checksum of a full window
// depends on cdf_pkg
module cdf_check (
  input  logic [7:0]          win [cdf_pkg::WIN_LEN],
  output logic                bad,
  output cdf_pkg::frame_res_t res
);

  logic [7:0] sum;
  logic       ok;

  // 8-bit additive checksum over the first five bytes
  assign sum = win[0] + win[1] + win[2] + win[3] + win[4];

  assign ok = (win[0] == cdf_pkg::SYNC_BYTE) &&
              (win[1] <= cdf_pkg::FLAG_MAX) &&
              (win[2] <= cdf_pkg::FLAG_MAX) &&
              (win[3] <= cdf_pkg::ZCAL_MAX) &&
              (win[4] <= cdf_pkg::FLAG_MAX) &&
              (sum == win[5]);

  assign bad = !ok;

  // fields only on an accepted frame, zeros on a reject
  always_comb begin
    if (ok) begin
      res.status = cdf_pkg::STATUS_OK;
      res.motion = win[1][0];
      res.speed  = win[2][0];
      res.zcal   = win[3][1:0];
      res.estop  = (win[4] == cdf_pkg::STOP_PRESSED);
    end else begin
      res.status = cdf_pkg::STATUS_REJECT;
      res.motion = 1'b0;
      res.speed  = 1'b0;
      res.zcal   = 2'b00;
      res.estop  = 1'b0;
    end
  end

endmodule

// ===== sv/control_frame_deframer_unit.sv =====
// control frame deframer top: window cell chain, frame checker, result register
// depends on cdf_pkg, cdf_cell, cdf_check and assert_macros.svh
//
//   channel  handshake              payload
//   rx       rx_valid / rx_ready    rx_byte
//   res      res_valid / res_ready  frame_status, motion_control, speed_zero,
//                                   zero_calibration, emergency_stop
//
// one received word per cycle while rx_ready is high; a word that completes a
// six byte window gives its result in the output register on the next cycle.
// the rate is set by the five cell window shifting once per word, with the
// checksum add and compare between the cells and the result register.
// rx_ready drops only while a result sits unread and res_ready is low.
// reset empties the window and the result register.
`include "assert_macros.svh"

module control_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       frame_status,
  output logic       motion_control,
  output logic       speed_zero,
  output logic [1:0] zero_calibration,
  output logic       emergency_stop
);

  localparam int DEPTH = cdf_pkg::HIST_DEPTH;

  cdf_pkg::cell_ctl_t  ctl;
  cdf_pkg::frame_res_t chk_res;
  logic                chk_bad;
  logic [7:0]          cell_byte  [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_seen;
  logic [7:0]          win        [cdf_pkg::WIN_LEN];
  logic                rx_take;

  // word handshake: take a word unless an unread result blocks the register
  assign rx_ready = !res_valid || res_ready;
  assign rx_take  = rx_valid && rx_ready;

  // the window is full when the oldest cell holds a byte
  assign ctl.shift = rx_take;
  assign ctl.full  = cell_valid[0];
  assign ctl.bad   = chk_bad;

  // cell chain: bytes move one cell toward the oldest end per word
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [7:0] b_in;
    logic       v_in;
    logic       s_in;

    if (j == DEPTH - 1) begin : g_last
      assign b_in = rx_byte;
      assign v_in = cell_valid[j] | (rx_byte == cdf_pkg::SYNC_BYTE);
    end else begin : g_mid
      assign b_in = cell_byte[j+1];
      assign v_in = cell_valid[j+1];
    end

    if (j == 0) begin : g_first
      assign s_in = 1'b0;
    end else begin : g_rest
      assign s_in = cell_seen[j-1];
    end

    cdf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .byte_in  (b_in),
      .valid_in (v_in),
      .seen_in  (s_in),
      .byte_q   (cell_byte[j]),
      .valid_q  (cell_valid[j]),
      .seen_out (cell_seen[j])
    );

    assign win[j] = cell_byte[j];
  end

  assign win[DEPTH] = rx_byte;

  // frame check on stored bytes plus the incoming word
  cdf_check u_check (
    .win (win),
    .bad (chk_bad),
    .res (chk_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_take && ctl.full) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take && ctl.full) begin
      frame_status     <= chk_res.status;
      motion_control   <= chk_res.motion;
      speed_zero       <= chk_res.speed;
      zero_calibration <= chk_res.zcal;
      emergency_stop   <= chk_res.estop;
    end
  end

  `CDF_ASSERT(a_window_suffix, clk, rst, (cell_valid & ~{1'b1, cell_valid[DEPTH-1:1]}) == '0)
  `CDF_ASSERT(a_oldest_sync, clk, rst, !cell_valid[0] || (cell_byte[0] == cdf_pkg::SYNC_BYTE))
  `CDF_ASSERT_NEXT(a_full_gives_result, clk, rst, rx_take && ctl.full, res_valid)
  `CDF_ASSERT_NEXT(a_good_empties, clk, rst, rx_take && ctl.full && !chk_bad, cell_valid == '0)

endmodule

// ===== verif/control_frame_deframer_checker.sv =====
// scoreboard for the control frame deframer: predicts results from accepted words
// and compares them with the result channel; depends on cdf_pkg
module control_frame_deframer_checker
  import cdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_ready,
  input  logic [7:0] rx_byte,
  input  logic       res_valid,
  input  logic       res_ready,
  input  logic       frame_status,
  input  logic       motion_control,
  input  logic       speed_zero,
  input  logic [1:0] zero_calibration,
  input  logic       emergency_stop,
  output int         fail_count,
  output int         results_due,
  output int         good_frames,
  output int         rejected_frames
);

  // predicted window state
  logic [7:0] kept_bytes [0:HIST_DEPTH-1];
  int         kept_count;

  frame_res_t frame_results_q [$];
  int         n_fail;
  int         n_good;
  int         n_reject;

  initial begin
    n_fail   = 0;
    n_good   = 0;
    n_reject = 0;
  end

  task automatic report_mismatch(input string what, input logic [1:0] want,
                                 input logic [1:0] got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    n_fail++;
  endtask

  task automatic check_field(input string what, input logic [1:0] want,
                             input logic [1:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  // one received word through the window; queues a result when six bytes are in
  task automatic deframe_word(input logic [7:0] b);
    logic [7:0] win [0:WIN_LEN-1];
    logic [7:0] sum;
    frame_res_t r;
    int         n;
    int         start;
    int         i;
    for (i = 0; i < HIST_DEPTH; i++) win[i] = kept_bytes[i];
    win[kept_count] = b;
    n = kept_count + 1;
    start = 0;
    if (n == WIN_LEN) begin
      sum = win[0] + win[1] + win[2] + win[3] + win[4];
      if (win[0] == SYNC_BYTE && win[1] <= FLAG_MAX && win[2] <= FLAG_MAX &&
          win[3] <= ZCAL_MAX && win[4] <= FLAG_MAX && sum == win[5]) begin
        r.status = STATUS_OK;
        r.motion = win[1][0];
        r.speed  = win[2][0];
        r.zcal   = win[3][1:0];
        r.estop  = (win[4] == STOP_PRESSED);
        n = 0;
        n_good++;
      end else begin
        r = '0;
        r.status = STATUS_REJECT;
        start = 1;
        n_reject++;
      end
      frame_results_q.push_back(r);
    end
    // realign on the next sync
    while (start < n && win[start] != SYNC_BYTE) start++;
    kept_count = n - start;
    for (i = 0; i < kept_count; i++) kept_bytes[i] = win[start + i];
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    frame_res_t want;
    if (rst) begin
      kept_count = 0;
      for (int i = 0; i < HIST_DEPTH; i++) kept_bytes[i] = '0;
      frame_results_q.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (frame_results_q.size() == 0) begin
          report_mismatch("result with none due, status", 2'd0, {1'b0, frame_status});
        end else begin
          want = frame_results_q.pop_front();
          check_field("frame_status", {1'b0, want.status}, {1'b0, frame_status});
          check_field("motion_control", {1'b0, want.motion}, {1'b0, motion_control});
          check_field("speed_zero", {1'b0, want.speed}, {1'b0, speed_zero});
          check_field("zero_calibration", want.zcal, zero_calibration);
          check_field("emergency_stop", {1'b0, want.estop}, {1'b0, emergency_stop});
        end
      end
      if (rx_valid && rx_ready) deframe_word(rx_byte);
    end
    fail_count      <= n_fail;
    results_due     <= frame_results_q.size();
    good_frames     <= n_good;
    rejected_frames <= n_reject;
  end

endmodule

// ===== verif/control_frame_deframer_unit_tb.sv =====
// testbench top for the control frame deframer: drives received words and result
// back-pressure, gives the verdict; depends on cdf_pkg, the deframer and its checker
module control_frame_deframer_unit_tb;
  import cdf_pkg::*;

  localparam int NUM_WORDS   = 1250;
  localparam int STALL_LIMIT = 1000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = '0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic       frame_status;
  logic       motion_control;
  logic       speed_zero;
  logic [1:0] zero_calibration;
  logic       emergency_stop;

  int fail_count;
  int results_due;
  int good_frames;
  int rejected_frames;
  int words_sent = 0;
  int idle_cycles = 0;
  bit burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  control_frame_deframer_unit dut (
    .clk, .rst, .rx_valid, .rx_ready, .rx_byte, .res_valid, .res_ready,
    .frame_status, .motion_control, .speed_zero, .zero_calibration, .emergency_stop
  );

  control_frame_deframer_checker checker_i (
    .clk, .rst, .rx_valid, .rx_ready, .rx_byte, .res_valid, .res_ready,
    .frame_status, .motion_control, .speed_zero, .zero_calibration, .emergency_stop,
    .fail_count, .results_due, .good_frames, .rejected_frames
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold one word until it is taken, then maybe idle
  task automatic send_word(input logic [7:0] b);
    int gap;
    rx_byte  <= b;
    rx_valid <= 1'b1;
    do @(posedge clk); while (!rx_ready);
    words_sent++;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // a status frame with random fields, optionally with one byte spoiled
  task automatic send_frame(input bit spoil);
    logic [7:0] f [0:WIN_LEN-1];
    int         idx;
    f[0] = SYNC_BYTE;
    f[1] = 8'($urandom_range(0, 1));
    f[2] = 8'($urandom_range(0, 1));
    f[3] = 8'($urandom_range(0, 2));
    f[4] = 8'($urandom_range(0, 1));
    f[5] = f[0] + f[1] + f[2] + f[3] + f[4];
    if (spoil) begin
      idx = $urandom_range(0, WIN_LEN - 1);
      case (idx)
        0: f[0] = SYNC_BYTE + 8'($urandom_range(1, 254));
        3: f[3] = 8'($urandom_range(3, 255));
        5: f[5] = f[5] ^ 8'($urandom_range(1, 255));
        default: f[idx] = 8'($urandom_range(2, 255));
      endcase
    end
    for (int i = 0; i < WIN_LEN; i++) send_word(f[i]);
  endtask

  // result side back-pressure
  initial begin
    int run;
    int gap;
    @(negedge rst);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      res_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // no progress on either channel for too long
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [7:0] directed [0:26];
    bit paused;
    int kind;
    int k;
    directed = '{
      8'hFF, 8'h00,                                  // noise outside a frame
      8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02,      // idle heartbeat
      8'h01, 8'h01, 8'h01, 8'h02, 8'h00, 8'h05,      // all flags set, stop pressed
      8'h01, 8'h00, 8'h00, 8'h03, 8'h00, 8'h04,      // calibration code out of range
      8'h01, 8'h01, 8'h00, 8'h00, 8'h01, 8'hFF,      // bad checksum, inner sync kept
      8'h00                                          // completes the realigned window
    };
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_word(directed[i]);

    while (words_sent < NUM_WORDS) begin
      burst = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        send_frame(1'b0);
      end else if (kind < 75) begin
        send_frame(1'b1);
      end else if (kind < 90) begin
        k = $urandom_range(1, 4);
        repeat (k) send_word(8'($urandom_range(0, 255)));
      end else begin
        // sync followed by a short tail, leaves the window part filled
        send_word(SYNC_BYTE);
        k = $urandom_range(0, 4);
        repeat (k) send_word(8'($urandom_range(0, 3)));
      end
      // drain everything once mid run
      if (!paused && words_sent >= NUM_WORDS / 2) begin
        paused = 1'b1;
        rx_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
      end
    end

    rx_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d received words with random gaps and back-pressure", words_sent);
    $display("checked %0d good frames and %0d rejected sync candidates",
             good_frames, rejected_frames);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
